// ----- rtl/oeb_pkg.sv -----
// Package: shared types, constants and the arctangent table of the obstacle brake.
package oeb_pkg;

    localparam int MaxRays      = 1024;
    localparam int IdxW         = $clog2(MaxRays);
    localparam int CordicSteps  = 15;
    localparam int CordicW      = 36;
    localparam int AngHalfPi    = 25736;
    localparam int AngPi        = 51472;
    localparam int AngTwoPi     = 102944;
    localparam int AngModSteps  = 6;
    localparam int CordicGain   = 39797;
    localparam int SpeedNum     = 25132741;
    localparam int SpeedMax     = 1048575;
    localparam int MotorLimit   = 999;
    localparam int ScanOffset   = 100;
    localparam int SonarLimit   = 500;
    localparam logic [16:0] RunNone = 17'h1FFFF;

    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_SENS  = 2'd1,
        ACT_DRIVE = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_RANGE_MIN  = 3'd0,
        REG_RANGE_MAX  = 3'd1,
        REG_FIRST_ANG  = 3'd2,
        REG_ANG_STEP   = 3'd3,
        REG_HALF_WIDTH = 3'd4,
        REG_MARGIN     = 3'd5,
        REG_DECEL      = 3'd6
    } reg_idx_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;      // capture request
        logic ang_mul;   // form ray angle
        logic ang_mod;   // one reduction step of the angle
        logic cor_init;  // set up rotation
        logic cor_step;  // one rotation step
        logic ray_done;  // fold ray into minimum, close scan
        logic div_init;
        logic div_step;
        logic sens_done;
        logic tick_dist;
        logic tick_mul;
        logic tick_done;
        logic drive_done;
    } oeb_cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic [1:0] action;
        logic       mod_done;
        logic       cor_last;
        logic       div_last;
    } oeb_stat_t;

    function automatic logic [13:0] atan_lut(input logic [3:0] k);
        logic [13:0] r;
        begin
            case (k)
                4'd0:  r = 14'd12868;
                4'd1:  r = 14'd7596;
                4'd2:  r = 14'd4014;
                4'd3:  r = 14'd2037;
                4'd4:  r = 14'd1023;
                4'd5:  r = 14'd512;
                4'd6:  r = 14'd256;
                4'd7:  r = 14'd128;
                4'd8:  r = 14'd64;
                4'd9:  r = 14'd32;
                4'd10: r = 14'd16;
                4'd11: r = 14'd8;
                4'd12: r = 14'd4;
                4'd13: r = 14'd2;
                4'd14: r = 14'd1;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/oeb_ctrl.sv -----
// Controller: sequences each request through the shared datapath units.
module oeb_ctrl import oeb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      out_free,
    input  oeb_stat_t stat,
    output logic      busy,
    output oeb_cmd_t  cmd
);
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DISP  = 10'b0000000010,
        ST_AMUL  = 10'b0000000100,
        ST_AMOD  = 10'b0000001000,
        ST_COR   = 10'b0000010000,
        ST_RAY   = 10'b0000100000,
        ST_DIV   = 10'b0001000000,
        ST_TDIST = 10'b0010000000,
        ST_TMUL  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (stat.action)
                    ACT_SCAN: begin
                        cmd.ang_mul = 1'b1;
                        state_next = ST_AMUL;
                    end
                    ACT_SENS: begin
                        cmd.div_init = 1'b1;
                        state_next = ST_DIV;
                    end
                    ACT_DRIVE: state_next = ST_OUT;
                    default: begin
                        cmd.tick_dist = 1'b1;
                        state_next = ST_TDIST;
                    end
                endcase
            end
            ST_AMUL: begin
                cmd.ang_mod = 1'b1;
                state_next = ST_AMOD;
            end
            ST_AMOD: begin
                if (stat.mod_done) begin
                    cmd.cor_init = 1'b1;
                    state_next = ST_COR;
                end else begin
                    cmd.ang_mod = 1'b1;
                end
            end
            ST_COR: begin
                cmd.cor_step = 1'b1;
                if (stat.cor_last) state_next = ST_RAY;
            end
            ST_RAY: begin
                cmd.ray_done = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_TDIST: begin
                cmd.tick_mul = 1'b1;
                state_next = ST_TMUL;
            end
            ST_TMUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    if (stat.action == ACT_SENS) cmd.sens_done = 1'b1;
                    if (stat.action == ACT_TICK) cmd.tick_done = 1'b1;
                    if (stat.action == ACT_DRIVE) cmd.drive_done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ----- rtl/oeb_datapath.sv -----
// Datapath: angle reduction, rotation unit, restoring divider, multiplier and state.
module oeb_datapath import oeb_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  oeb_cmd_t            cmd,
    output oeb_stat_t           stat,
    input  logic [88:0]         in_data,
    input  logic                in_last,
    input  logic [1:0]          in_user,
    input  logic                cfg_fire,
    input  logic [2:0]          cfg_idx,
    input  logic [16:0]         cfg_data,
    output logic                res_valid,
    output logic signed [10:0]  res_motor,
    output logic signed [10:0]  res_steer,
    output logic                res_brake
);
    // configuration
    logic [15:0] range_min_reg, range_max_reg, decel_reg;
    logic signed [16:0] first_ang_reg;
    logic [11:0] ang_step_reg, half_w_reg, margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg <= 16'd450;
            range_max_reg <= 16'd10000;
            first_ang_reg <= -17'sd8192;
            ang_step_reg  <= 12'd26;
            half_w_reg    <= 12'd100;
            margin_reg    <= 12'd100;
            decel_reg     <= 16'd900;
        end else if (cfg_fire) begin
            unique case (cfg_idx)
                REG_RANGE_MIN:  range_min_reg <= cfg_data[15:0];
                REG_RANGE_MAX:  range_max_reg <= cfg_data[15:0];
                REG_FIRST_ANG:  first_ang_reg <= cfg_data;
                REG_ANG_STEP:   ang_step_reg  <= cfg_data[11:0];
                REG_HALF_WIDTH: half_w_reg    <= cfg_data[11:0];
                REG_MARGIN:     margin_reg    <= cfg_data[11:0];
                REG_DECEL:      decel_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured request
    logic [1:0]  act_reg;
    logic [15:0] rr_reg, sonar_in_reg;
    logic [9:0]  ridx_reg;
    logic        rlast_reg, hvalid_reg;
    logic [23:0] hper_reg;
    logic signed [10:0] mreq_reg, sreq_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg      <= in_user;
            rr_reg       <= in_data[15:0];
            ridx_reg     <= in_data[25:16];
            rlast_reg    <= in_last;
            sonar_in_reg <= in_data[41:26];
            hper_reg     <= in_data[65:42];
            hvalid_reg   <= in_data[66];
            mreq_reg     <= in_data[77:67];
            sreq_reg     <= in_data[88:78];
        end
    end

    // state
    logic        braking_reg;
    logic [10:0] held_reg;
    logic [15:0] sonar_reg;
    logic [19:0] speed_reg;
    logic [16:0] runmin_reg;
    logic [15:0] scand_reg;
    logic        seen_reg;
    logic [15:0] obst_reg;

    // angle and rotation
    logic [22:0] ang_reg;   // |angle|, reduced
    logic [2:0]  mk_reg;    // shift of the modulus tried in this reduction step
    logic        mod_done_reg;
    logic        qual_reg;
    logic        back_reg;
    logic signed [CordicW-1:0] x_reg, y_reg;
    logic signed [17:0] z_reg;
    logic [3:0]  k_reg;

    logic signed [23:0] ang_full;
    assign ang_full = $signed({14'd0, ridx_reg}) * $signed({12'd0, ang_step_reg})
                      + 24'(first_ang_reg);

    logic [22:0] mod_sub;
    assign mod_sub = 23'(AngTwoPi) << mk_reg;

    assign stat.mod_done = mod_done_reg;
    assign stat.cor_last = (k_reg == 4'(CordicSteps - 1));
    assign stat.action   = act_reg;

    logic signed [CordicW-1:0] dx, dy;
    logic [13:0] at;
    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign at = atan_lut(k_reg);

    logic signed [CordicW-1:0] xf;
    logic signed [CordicW-17:0] dfl;
    logic [16:0] dclamp;
    assign xf  = back_reg ? -x_reg : x_reg;
    assign dfl = xf[CordicW-1:16];
    assign dclamp = dfl[CordicW-17] ? 17'd0 :
                    (|dfl[CordicW-17:16]) ? 17'd65535 : {1'b0, dfl[15:0]};

    // the index field is exactly wide enough for MaxRays, so every index is in range
    logic ray_in;
    assign ray_in = (rr_reg > range_min_reg) && (rr_reg < range_max_reg);

    always_ff @(posedge aclk) begin
        if (cmd.ang_mul) begin
            ang_reg      <= ang_full[23] ? 23'(-ang_full) : ang_full[22:0];
            mk_reg       <= 3'(AngModSteps - 1);
            mod_done_reg <= 1'b0;
        end
        // restoring reduction: try 2*pi shifted down one place per cycle
        if (cmd.ang_mod) begin
            if (ang_reg >= mod_sub) ang_reg <= ang_reg - mod_sub;
            if (mk_reg == 3'd0) mod_done_reg <= 1'b1;
            else mk_reg <= mk_reg - 3'd1;
        end
        if (cmd.cor_init) begin
            qual_reg <= ray_in && (ang_reg < 23'(AngPi));
            back_reg <= ang_reg > 23'(AngHalfPi);
            z_reg    <= (ang_reg > 23'(AngHalfPi)) ? 18'(AngPi - int'(ang_reg))
                                                    : 18'(ang_reg);
            x_reg    <= $signed({20'd0, rr_reg}) * $signed(36'(CordicGain));
            y_reg    <= '0;
            k_reg    <= '0;
        end
        if (cmd.cor_step) begin
            if (!z_reg[17]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - 18'(at);
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + 18'(at);
            end
            k_reg <= k_reg + 4'd1;
        end
    end

    // divider: 25132741 / dt, 25 quotient bits, one per cycle
    logic [24:0] q_reg;
    logic [24:0] rem_reg;
    logic [4:0]  dk_reg;
    logic [25:0] trial;
    logic [24:0] numb;
    assign numb = 25'(SpeedNum);
    assign trial = {rem_reg, numb[dk_reg]} - {2'b0, hper_reg};
    assign stat.div_last = (dk_reg == 5'd0);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= '0;
            q_reg   <= '0;
            dk_reg  <= 5'd24;
        end
        if (cmd.div_step) begin
            if (!trial[25]) begin
                rem_reg <= trial[24:0];
                q_reg   <= {q_reg[23:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[23:0], numb[dk_reg]};
                q_reg   <= {q_reg[23:0], 1'b0};
            end
            dk_reg <= dk_reg - 5'd1;
        end
    end

    // tick: distance then products
    logic [15:0] dsel;
    logic [15:0] obst_new;
    always_comb begin
        dsel = scand_reg;
        if (sonar_reg != 16'd0 && sonar_reg < 16'(SonarLimit) && sonar_reg < dsel)
            dsel = sonar_reg;
    end
    assign obst_new = (dsel > {4'd0, margin_reg}) ? dsel - {4'd0, margin_reg} : 16'd0;

    logic [39:0] v2_reg;
    logic [31:0] ad_reg;
    always_ff @(posedge aclk) begin
        if (cmd.tick_mul) begin
            v2_reg <= 40'(speed_reg) * 40'(speed_reg);
            ad_reg <= 32'(decel_reg) * 32'(obst_reg);
        end
    end

    logic stop_now, release_now;
    assign stop_now    = !braking_reg && (v2_reg > {7'd0, ad_reg, 1'b0});
    assign release_now = braking_reg && ({v2_reg, 1'b0} < {9'd0, ad_reg});

    logic signed [10:0] mclamp;
    assign mclamp = braking_reg ? ((mreq_reg > 11'sd0) ? 11'sd0 : mreq_reg)
                                : ((mreq_reg > 11'sd999) ? 11'sd999 : mreq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            braking_reg <= 1'b0;
            held_reg    <= '0;
            sonar_reg   <= 16'd2000;
            speed_reg   <= '0;
            runmin_reg  <= RunNone;
            scand_reg   <= '0;
            seen_reg    <= 1'b0;
            obst_reg    <= 16'd10000;
            res_valid   <= 1'b0;
        end else begin
            res_valid <= 1'b0;
            if (cmd.ray_done) begin
                logic [16:0] m;
                logic signed [17:0] v;
                m = runmin_reg;
                if (qual_reg && (y_reg < $signed({{(CordicW-28){1'b0}}, half_w_reg, 16'd0}))
                    && dclamp < m)
                    m = dclamp;
                if (rlast_reg) begin
                    v = $signed({1'b0, m}) - 18'(ScanOffset);
                    if (m == RunNone) scand_reg <= range_max_reg;
                    else if (v < 0) scand_reg <= '0;
                    else if (v > $signed({2'b0, range_max_reg})) scand_reg <= range_max_reg;
                    else scand_reg <= v[15:0];
                    seen_reg   <= 1'b1;
                    runmin_reg <= RunNone;
                end else begin
                    runmin_reg <= m;
                end
            end
            if (cmd.sens_done) begin
                sonar_reg <= sonar_in_reg;
                if (hvalid_reg) begin
                    speed_reg <= (hper_reg == 24'd0 || |q_reg[24:20]) ? 20'(SpeedMax)
                                                                       : q_reg[19:0];
                end
            end
            if (cmd.tick_dist && seen_reg) obst_reg <= obst_new;
            if (cmd.tick_done) begin
                if (stop_now) begin
                    braking_reg <= 1'b1;
                    res_valid   <= 1'b1;
                    res_motor   <= '0;
                    res_steer   <= held_reg;
                    res_brake   <= 1'b1;
                end
                if (release_now) braking_reg <= 1'b0;
            end
            if (cmd.drive_done) begin
                held_reg  <= sreq_reg;
                res_valid <= 1'b1;
                res_motor <= mclamp;
                res_steer <= sreq_reg;
                res_brake <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/obstacle_emergency_brake.sv -----
// Top level: obstacle emergency brake, controller plus datapath and output register.
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_tvalid / s_tready    | s_tdata, s_tlast (ray_last), s_tuser (action)
//  m_axis   | out | m_tvalid / m_tready    | m_tdata, m_tuser (is_brake_command)
//  cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// Scan request: busy through a six-step angle reduction plus 15 rotation steps.
// Sensor request: busy while the 25-step bit-serial speed divider runs.
// Drive request: dispatch, output; tick request: distance, products, output. One request at a time.
// Sensor, drive and tick requests also wait while the result register is held.
// Synchronous active-low reset; no clearing pass.
module obstacle_emergency_brake import oeb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // ray_range, ray_index, front_sonar, hall_period,
                                   // hall_period_valid, motor_request, steering_request
    input  logic         s_tlast,
    input  logic [1:0]   s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,  // motor_out, steering_out
    output logic         m_tuser,  // is_brake_command
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [16:0]  cfg_data
);
    oeb_cmd_t  cmd;
    oeb_stat_t stat;
    logic busy, res_valid, res_brake;
    logic signed [10:0] res_motor, res_steer;
    logic out_valid_reg;
    logic [23:0] out_data_reg;
    logic out_user_reg;

    assign s_tready  = !busy;
    assign cfg_ready = 1'b1;

    oeb_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_fire (s_tvalid && s_tready),
        .out_free(!out_valid_reg || m_tready),
        .stat, .busy, .cmd
    );

    oeb_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_data  (s_tdata[88:0]),
        .in_last  (s_tlast),
        .in_user  (s_tuser),
        .cfg_fire (cfg_valid && cfg_ready),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .res_valid, .res_motor, .res_steer, .res_brake
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_data_reg <= {2'b0, res_steer, res_motor};
            out_user_reg <= res_brake;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
endmodule

// ----- rtl/oeb_checker.sv -----
// Port checker for the obstacle emergency brake, bound to the top level.
module oeb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_brake_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[10:0] == 11'd0)
        else $error("stop command with nonzero motor level");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind obstacle_emergency_brake oeb_checker u_oeb_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
